FILE: sv/wspf_pkg.sv
// ----------------------------------------------------------------------------
// wspf_pkg
// Shared constants, register codes and types of the wheel speed controller.
// ----------------------------------------------------------------------------
package wspf_pkg;

  // number of wheels with a state entry
  localparam int WHEEL_COUNT = 4;
  localparam int ADDR_W      = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  // state entry: last count, integral, previous error
  localparam int STATE_W = 16 + 32 + 32;

  // shared multiplier: wide magnitude times narrow factor, two partial products
  localparam int MUL_A_W = 56;
  localparam int MUL_B_W = 24;
  localparam int MUL_H_W = MUL_A_W / 2;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // shared bit-serial divider
  localparam int DIV_N_W = 56;
  localparam int DIV_D_W = 20;
  localparam int DIV_C_W = $clog2(DIV_N_W + 1);

  localparam logic [19:0] MICRO      = 20'd1000000;
  localparam logic [19:0] HALF_MICRO = 20'd500000;
  localparam logic [79:0] TERM_LIM   = 80'h1 << 61;

  // reciprocal of one million, 2^67 / 1e6 rounded up, in two 24-bit halves;
  // exact quotient for numerators below 2^47
  localparam logic [23:0] RECIP_HI = 24'h8637BD;
  localparam logic [23:0] RECIP_LO = 24'h05AF6D;
  localparam int          RECIP_SH = 43;

  // configuration register codes
  localparam logic [2:0] REG_MPT      = 3'd0;
  localparam logic [2:0] REG_GAIN_P   = 3'd1;
  localparam logic [2:0] REG_GAIN_I   = 3'd2;
  localparam logic [2:0] REG_GAIN_D   = 3'd3;
  localparam logic [2:0] REG_ICLAMP   = 3'd4;
  localparam logic [2:0] REG_DEADBAND = 3'd5;
  localparam logic [2:0] REG_STATIC   = 3'd6;
  localparam logic [2:0] REG_DLIMIT   = 3'd7;

  typedef struct packed {
    logic [23:0] metres_per_tick;
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
    logic [22:0] integral_clamp;
    logic [16:0] speed_deadband;
    logic [7:0]  static_drive;
    logic [7:0]  drive_limit;
  } cfg_t;

endpackage

FILE: sv/wspf_ram.sv
// ----------------------------------------------------------------------------
// wspf_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module wspf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/wspf_mul.sv
// ----------------------------------------------------------------------------
// wspf_mul
// Unsigned magnitude multiplier, two partial products accumulated in turn.
// ----------------------------------------------------------------------------
module wspf_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wspf_pkg::MUL_A_W-1:0]  a,
  input  logic [wspf_pkg::MUL_B_W-1:0]  b,
  output logic                          done,
  output logic [wspf_pkg::MUL_P_W-1:0]  prod
);

  localparam int PP_W = wspf_pkg::MUL_H_W + wspf_pkg::MUL_B_W;

  logic [wspf_pkg::MUL_A_W-1:0] a_r;
  logic [wspf_pkg::MUL_B_W-1:0] b_r;
  logic [1:0]                   ph;
  logic [PP_W-1:0]              pp_lo;
  logic [PP_W-1:0]              pp_hi;

  assign pp_lo = a_r[wspf_pkg::MUL_H_W-1:0] * b_r;
  assign pp_hi = a_r[wspf_pkg::MUL_A_W-1:wspf_pkg::MUL_H_W] * b_r;

  // phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= (ph == 2'd2);
      if (start) begin
        ph <= 2'd1;
      end else if (ph != 2'd0) begin
        ph <= (ph == 2'd2) ? 2'd0 : 2'd2;
      end
    end
  end

  // operands and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph == 2'd1) begin
      prod <= wspf_pkg::MUL_P_W'(pp_lo);
    end else if (ph == 2'd2) begin
      prod <= prod + {pp_hi, {wspf_pkg::MUL_H_W{1'b0}}};
    end
  end

endmodule

FILE: sv/wspf_div.sv
// ----------------------------------------------------------------------------
// wspf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wspf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wspf_pkg::DIV_N_W-1:0]  num,
  input  logic [wspf_pkg::DIV_D_W-1:0]  den,
  output logic                          done,
  output logic [wspf_pkg::DIV_N_W-1:0]  quot
);

  logic [wspf_pkg::DIV_C_W-1:0] cnt;
  logic [wspf_pkg::DIV_D_W-1:0] den_r;
  logic [wspf_pkg::DIV_D_W-1:0] rem;
  logic [wspf_pkg::DIV_D_W:0]   trial;
  logic                         ge;

  assign trial = {rem, quot[wspf_pkg::DIV_N_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == wspf_pkg::DIV_C_W'(1));
      if (start) begin
        cnt <= wspf_pkg::DIV_C_W'(wspf_pkg::DIV_N_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      den_r <= den;
      rem   <= '0;
    end else if (cnt != '0) begin
      quot <= {quot[wspf_pkg::DIV_N_W-2:0], ge};
      rem  <= ge ? wspf_pkg::DIV_D_W'(trial - {1'b0, den_r})
                 : trial[wspf_pkg::DIV_D_W-1:0];
    end
  end

endmodule

FILE: sv/wspf_cfg.sv
// ----------------------------------------------------------------------------
// wspf_cfg
// APB register file holding the controller settings.
// ----------------------------------------------------------------------------
module wspf_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output wspf_pkg::cfg_t     cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.metres_per_tick <= 24'd3189120;
      cfg.gain_p          <= 24'd30720;
      cfg.gain_i          <= 24'd25600;
      cfg.gain_d          <= 24'd1280;
      cfg.integral_clamp  <= 23'd78643;
      cfg.speed_deadband  <= 17'd131;
      cfg.static_drive    <= 8'd100;
      cfg.drive_limit     <= 8'd180;
    end else if (wr) begin
      unique case (idx)
        wspf_pkg::REG_MPT:      cfg.metres_per_tick <= pwdata[23:0];
        wspf_pkg::REG_GAIN_P:   cfg.gain_p          <= pwdata[23:0];
        wspf_pkg::REG_GAIN_I:   cfg.gain_i          <= pwdata[23:0];
        wspf_pkg::REG_GAIN_D:   cfg.gain_d          <= pwdata[23:0];
        wspf_pkg::REG_ICLAMP:   cfg.integral_clamp  <= pwdata[22:0];
        wspf_pkg::REG_DEADBAND: cfg.speed_deadband  <= pwdata[16:0];
        wspf_pkg::REG_STATIC:   cfg.static_drive    <= pwdata[7:0];
        wspf_pkg::REG_DLIMIT:   cfg.drive_limit     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      wspf_pkg::REG_MPT:      prdata = 32'(cfg.metres_per_tick);
      wspf_pkg::REG_GAIN_P:   prdata = 32'(cfg.gain_p);
      wspf_pkg::REG_GAIN_I:   prdata = 32'(cfg.gain_i);
      wspf_pkg::REG_GAIN_D:   prdata = 32'(cfg.gain_d);
      wspf_pkg::REG_ICLAMP:   prdata = 32'(cfg.integral_clamp);
      wspf_pkg::REG_DEADBAND: prdata = 32'(cfg.speed_deadband);
      wspf_pkg::REG_STATIC:   prdata = 32'(cfg.static_drive);
      wspf_pkg::REG_DLIMIT:   prdata = 32'(cfg.drive_limit);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: sv/wspf_core.sv
// ----------------------------------------------------------------------------
// wspf_core
// Per-wheel state memory and the sequencer that runs one control tick.
// ----------------------------------------------------------------------------
module wspf_core (
  input  logic                clk,
  input  logic                rst,
  input  wspf_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          wheel_number,
  input  logic signed [15:0]  encoder_count,
  input  logic signed [19:0]  target_speed,
  input  logic [15:0]         elapsed_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          wheel_out,
  output logic signed [8:0]   drive_signed,
  output logic [7:0]          bridge_fwd_duty,
  output logic [7:0]          bridge_rev_duty,
  output logic signed [31:0]  measured_speed
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_SPD_M = 4'd2;
  localparam logic [3:0] S_SPD_K = 4'd3;
  localparam logic [3:0] S_SPD_D = 4'd4;
  localparam logic [3:0] S_INT_M = 4'd5;
  localparam logic [3:0] S_INT_D = 4'd6;
  localparam logic [3:0] S_DER_M = 4'd7;
  localparam logic [3:0] S_DER_D = 4'd8;
  localparam logic [3:0] S_P_M   = 4'd9;
  localparam logic [3:0] S_I_M   = 4'd10;
  localparam logic [3:0] S_D_M   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [3:0] S_INT_H = 4'd14;
  localparam logic [3:0] S_INT_L = 4'd15;

  localparam int AW = wspf_pkg::ADDR_W;
  localparam int WHEEL_VEC = wspf_pkg::WHEEL_COUNT;

  logic [3:0] state;

  // item registers
  logic [1:0]         w_r;
  logic signed [15:0] cnt_r;
  logic signed [19:0] tgt_r;
  logic [15:0]        dt_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] prev_r;
  logic               dneg_r;
  logic signed [31:0] err_r;
  logic signed [31:0] integ_r;
  logic               diffneg_r;
  logic [wspf_pkg::DIV_N_W-1:0] deriv_r;
  logic signed [63:0] sum_r;
  logic signed [8:0]  res_drive;
  logic signed [31:0] res_speed;
  logic [wspf_pkg::MUL_P_W-1:0] rhi_r;
  logic [31:0]        iq_r;

  // unit control
  logic                         mul_go;
  logic [wspf_pkg::MUL_A_W-1:0] mul_a;
  logic [wspf_pkg::MUL_B_W-1:0] mul_b;
  logic                         mul_done;
  logic [wspf_pkg::MUL_P_W-1:0] mul_p;
  logic                         div_go;
  logic [wspf_pkg::DIV_N_W-1:0] div_num;
  logic [wspf_pkg::DIV_D_W-1:0] div_den;
  logic                         div_done;
  logic [wspf_pkg::DIV_N_W-1:0] div_q;

  // state memory
  logic [WHEEL_VEC-1:0] vld;
  logic                          ram_we;
  logic [wspf_pkg::STATE_W-1:0]  ram_wdata;
  logic [wspf_pkg::STATE_W-1:0]  ram_rdata;
  logic [wspf_pkg::STATE_W-1:0]  ent;
  logic                          accept;
  logic                          in_range;
  logic                          out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign in_range = (32'(w_r) < wspf_pkg::WHEEL_COUNT);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  wspf_ram #(.WIDTH(wspf_pkg::STATE_W), .DEPTH(wspf_pkg::WHEEL_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(w_r)),
    .wdata (ram_wdata),
    .raddr (AW'(wheel_number)),
    .rdata (ram_rdata)
  );

  wspf_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  wspf_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  // entries never written read as zero
  assign ent = vld[AW'(w_r)] ? ram_rdata : '0;

  // saturated signed term from a magnitude product
  function automatic logic signed [63:0] sat_term(input logic [79:0] p, input logic neg);
    logic [63:0] m;
    m = (p > wspf_pkg::TERM_LIM) ? 64'(wspf_pkg::TERM_LIM) : p[63:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // delta from stored count
  logic signed [16:0] delta_c;
  logic [16:0]        dmag_c;
  assign delta_c = 17'(cnt_r) - 17'($signed(ent[79:64]));
  assign dmag_c  = delta_c[16] ? 17'(-delta_c) : 17'(delta_c);

  // speed rounding numerator, then quotient saturation
  logic [62:0]        spd_num_c;
  logic signed [31:0] speed_c;
  assign spd_num_c = 63'(mul_p[61:0]) + 63'({dt_r, 15'b0});
  always_comb begin
    if (!dneg_r) begin
      speed_c = (div_q > 56'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]);
    end else begin
      speed_c = (div_q >= 56'h8000_0000) ? 32'sh8000_0000 : -$signed(div_q[31:0]);
    end
  end

  // error and deadband
  logic signed [32:0] err_w;
  logic signed [31:0] err_c;
  logic [19:0]        tmag_c;
  logic               dead_c;
  logic [32:0]        emag_c;
  assign err_w  = 33'(tgt_r) - 33'(speed_c);
  assign err_c  = (err_w > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (err_w < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(err_w);
  assign tmag_c = tgt_r[19] ? 20'(-tgt_r) : 20'(tgt_r);
  assign dead_c = (tmag_c < 20'(cfg.speed_deadband));
  assign emag_c = err_r[31] ? 33'(-33'(err_r)) : 33'(err_r);

  // integral step quotient from the two reciprocal partial products
  logic [wspf_pkg::MUL_P_W-1:0] rsum_c;
  assign rsum_c = rhi_r + (mul_p >> 24);

  // integral update and clamp
  logic signed [33:0] integ_w;
  logic signed [33:0] iclamp_s;
  logic signed [31:0] integ_c;
  logic signed [32:0] diff_c;
  logic [32:0]        diffmag_c;
  assign integ_w  = 34'(acc_r) + (err_r[31] ? -34'($signed({1'b0, iq_r}))
                                            : 34'($signed({1'b0, iq_r})));
  assign iclamp_s = 34'($signed({1'b0, cfg.integral_clamp}));
  assign integ_c  = (integ_w > iclamp_s) ? 32'(iclamp_s) :
                    (integ_w < -iclamp_s) ? 32'(-iclamp_s) : 32'(integ_w);
  assign diff_c    = 33'(err_r) - 33'(prev_r);
  assign diffmag_c = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);

  logic [31:0] imag_c;
  assign imag_c = integ_r[31] ? 32'(-integ_r) : 32'(integ_r);

  // static offset, clamp and rounding
  logic signed [63:0] ff_c;
  logic signed [63:0] tot_c;
  logic signed [63:0] lim_c;
  logic signed [63:0] clp_c;
  logic [63:0]        smag_c;
  logic [7:0]         dmag8_c;
  assign ff_c    = (tgt_r > 20'sd0) ? $signed({32'b0, cfg.static_drive, 24'b0})
                                    : -$signed({32'b0, cfg.static_drive, 24'b0});
  assign tot_c   = sum_r + ff_c;
  assign lim_c   = $signed({32'b0, cfg.drive_limit, 24'b0});
  assign clp_c   = (tot_c > lim_c) ? lim_c : (tot_c < -lim_c) ? -lim_c : tot_c;
  assign smag_c  = clp_c[63] ? 64'(-clp_c) : 64'(clp_c);
  assign dmag8_c = 8'((smag_c + 64'h80_0000) >> 24);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      mul_go    <= 1'b0;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
      ram_we    <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
      ram_we <= 1'b0;
      if (ram_we) begin
        vld[AW'(w_r)] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (accept) state <= S_READ;
        S_READ: begin
          if (!in_range) begin
            state <= S_OUT;
          end else begin
            mul_go <= 1'b1;
            state  <= S_SPD_M;
          end
        end
        S_SPD_M: if (mul_done) begin mul_go <= 1'b1; state <= S_SPD_K; end
        S_SPD_K: if (mul_done) begin div_go <= 1'b1; state <= S_SPD_D; end
        S_SPD_D: begin
          if (div_done) begin
            if (dead_c) begin
              ram_we <= 1'b1;
              state  <= S_OUT;
            end else begin
              mul_go <= 1'b1;
              state  <= S_INT_M;
            end
          end
        end
        S_INT_M: if (mul_done) begin mul_go <= 1'b1; state <= S_INT_H; end
        S_INT_H: if (mul_done) begin mul_go <= 1'b1; state <= S_INT_L; end
        S_INT_L: if (mul_done) state <= S_INT_D;
        S_INT_D: begin
          mul_go <= 1'b1;
          state  <= S_DER_M;
        end
        S_DER_M: if (mul_done) begin div_go <= 1'b1; state <= S_DER_D; end
        S_DER_D: if (div_done) begin mul_go <= 1'b1; state <= S_P_M; end
        S_P_M:   if (mul_done) begin mul_go <= 1'b1; state <= S_I_M; end
        S_I_M:   if (mul_done) begin mul_go <= 1'b1; state <= S_D_M; end
        S_D_M:   if (mul_done) state <= S_FIN;
        S_FIN: begin
          ram_we <= 1'b1;
          state  <= S_OUT;
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        w_r   <= wheel_number;
        cnt_r <= encoder_count;
        tgt_r <= target_speed;
        dt_r  <= (elapsed_us == 16'd0) ? 16'd1 : elapsed_us;
      end
      S_READ: begin
        acc_r     <= $signed(ent[63:32]);
        prev_r    <= $signed(ent[31:0]);
        dneg_r    <= delta_c[16];
        mul_a     <= wspf_pkg::MUL_A_W'(dmag_c);
        mul_b     <= cfg.metres_per_tick;
        res_drive <= '0;
        res_speed <= '0;
      end
      S_SPD_M: begin
        mul_a <= mul_p[wspf_pkg::MUL_A_W-1:0];
        mul_b <= wspf_pkg::MUL_B_W'(wspf_pkg::MICRO);
      end
      S_SPD_K: begin
        div_num <= wspf_pkg::DIV_N_W'(spd_num_c >> 16);
        div_den <= wspf_pkg::DIV_D_W'(dt_r);
      end
      S_SPD_D: begin
        res_speed <= speed_c;
        err_r     <= err_c;
        mul_b     <= wspf_pkg::MUL_B_W'(dt_r);
        ram_wdata <= {cnt_r, 64'b0};
        mul_a     <= wspf_pkg::MUL_A_W'(err_c[31] ? 33'(-33'(err_c)) : 33'(err_c));
      end
      S_INT_M: begin
        // rounding numerator times the upper reciprocal half
        mul_a <= wspf_pkg::MUL_A_W'(mul_p[47:0]) +
                 wspf_pkg::MUL_A_W'(wspf_pkg::HALF_MICRO);
        mul_b <= wspf_pkg::RECIP_HI;
      end
      S_INT_H: begin
        rhi_r <= mul_p;
        mul_b <= wspf_pkg::RECIP_LO;
      end
      S_INT_L: iq_r <= rsum_c[wspf_pkg::RECIP_SH+31:wspf_pkg::RECIP_SH];
      S_INT_D: begin
        integ_r   <= integ_c;
        diffneg_r <= diff_c[32];
        mul_a     <= wspf_pkg::MUL_A_W'(diffmag_c);
        mul_b     <= wspf_pkg::MUL_B_W'(wspf_pkg::MICRO);
      end
      S_DER_M: begin
        div_num <= mul_p[wspf_pkg::DIV_N_W-1:0] + wspf_pkg::DIV_N_W'(dt_r >> 1);
        div_den <= wspf_pkg::DIV_D_W'(dt_r);
      end
      S_DER_D: begin
        deriv_r <= div_q;
        mul_a   <= wspf_pkg::MUL_A_W'(emag_c);
        mul_b   <= cfg.gain_p;
      end
      S_P_M: begin
        sum_r <= sat_term(mul_p, err_r[31]);
        mul_a <= wspf_pkg::MUL_A_W'(imag_c);
        mul_b <= cfg.gain_i;
      end
      S_I_M: begin
        if (mul_done) begin
          sum_r <= sum_r + sat_term(mul_p, integ_r[31]);
        end
        mul_a <= deriv_r;
        mul_b <= cfg.gain_d;
      end
      S_D_M: if (mul_done) sum_r <= sum_r + sat_term(mul_p, diffneg_r);
      S_FIN: begin
        res_drive <= clp_c[63] ? -$signed({1'b0, dmag8_c}) : $signed({1'b0, dmag8_c});
        ram_wdata <= {cnt_r, integ_r, err_r};
      end
      default: ;
    endcase
    if (out_load) begin
      wheel_out       <= w_r;
      drive_signed    <= res_drive;
      bridge_fwd_duty <= (res_drive > 9'sd0) ? res_drive[7:0] : 8'd0;
      bridge_rev_duty <= (res_drive < 9'sd0) ? 8'(-res_drive) : 8'd0;
      measured_speed  <= res_speed;
    end
  end

  // an accepted tick reads its wheel entry in the next cycle
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted tick did not start the entry read");

  // the drive handed to the output stays within the drive limit
  a_drive_lim: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (res_drive <= $signed({1'b0, cfg.drive_limit})) &&
                 (res_drive >= -$signed({1'b0, cfg.drive_limit})))
    else $error("drive outside the configured limit");

  // multiplier and divider are never started together
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_go && div_go))
    else $error("multiplier and divider started in the same cycle");

  // state entry written only after the tick has been read
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_OUT) && in_range)
    else $error("state entry written outside the tick end");

endmodule

FILE: sv/wheel_speed_pid_with_static_feedforward_unit.sv
// ----------------------------------------------------------------------------
// wheel_speed_pid_with_static_feedforward_unit
// Per-wheel PID speed controller with static feedforward and H-bridge split.
// ----------------------------------------------------------------------------
// One tick is handled at a time. A tick runs the two divisions by the elapsed
// time in the shared bit-serial divider and nine multiplies in the shared
// two-partial-product multiplier, the division by one million being a
// reciprocal multiply; a target inside the deadband ends the tick after the
// speed division. The input stalls while a tick is in progress; a finished
// result sits in the output register, so the next tick is taken while it waits.
// Wheel state lives in one small RAM; each entry has a valid bit cleared at
// reset, so no clearing pass is needed after reset. Configuration is written
// over the APB port; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module wheel_speed_pid_with_static_feedforward_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         wheel_number,
  input  logic signed [15:0] encoder_count,
  input  logic signed [19:0] target_speed,
  input  logic [15:0]        elapsed_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         wheel_out,
  output logic signed [8:0]  drive_signed,
  output logic [7:0]         bridge_fwd_duty,
  output logic [7:0]         bridge_rev_duty,
  output logic signed [31:0] measured_speed
);

  wspf_pkg::cfg_t cfg;

  // settings registers
  wspf_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // control tick engine
  wspf_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall),
    .wheel_number(wheel_number), .encoder_count(encoder_count),
    .target_speed(target_speed), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .wheel_out(wheel_out), .drive_signed(drive_signed),
    .bridge_fwd_duty(bridge_fwd_duty), .bridge_rev_duty(bridge_rev_duty),
    .measured_speed(measured_speed)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the wheel speed PID block. Control ticks are sent with random gaps
// and output stalls, a built-in predictor of speed, PID and bridge split
// computes each drive command, and each transfer out is compared field by
// field. Several register settings are used, extremes among them.
// ----------------------------------------------------------------------------
module tb;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint TERM_MAX    = 64'sd1 << 61;

  typedef struct {
    logic [1:0]         wheel;
    logic signed [15:0] count;
    logic signed [19:0] target;
    logic [15:0]        dt;
  } tick_t;

  typedef struct {
    logic [1:0]         wheel;
    logic signed [8:0]  drive;
    logic [7:0]         fwd;
    logic [7:0]         rev;
    logic signed [31:0] speed;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic [1:0] wheel_number = '0;
  logic signed [15:0] encoder_count = '0;
  logic signed [19:0] target_speed = '0;
  logic [15:0] elapsed_us = '0;
  logic out_valid, out_stall = 1'b0;
  logic [1:0] wheel_out;
  logic signed [8:0] drive_signed;
  logic [7:0] bridge_fwd_duty, bridge_rev_duty;
  logic signed [31:0] measured_speed;

  tick_t  pending_ticks[$];
  cmd_t   expected_cmds[$];
  wspf_pkg::cfg_t cfg;
  logic [15:0] pred_last_count[wspf_pkg::WHEEL_COUNT];
  longint pred_integral[wspf_pkg::WHEEL_COUNT];
  longint pred_prev_err[wspf_pkg::WHEEL_COUNT];
  logic signed [15:0] gen_count[wspf_pkg::WHEEL_COUNT];
  int send_idle_pct = 0, stall_pct = 0;
  int errors = 0;
  longint cycles = 0;
  int sent_cnt = 0, taken_cnt = 0;

  wheel_speed_pid_with_static_feedforward_unit dut (.*);

  always #1 clk = ~clk;

  // rounded division, halves away from zero
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = num < 0 ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint gain_term(longint x, longint g);
    longint unsigned mag;
    if (g == 0 || x == 0) return 0;
    mag = x < 0 ? longint'(-x) : longint'(x);
    if (mag > longint'(TERM_MAX) / g) return x < 0 ? -TERM_MAX : TERM_MAX;
    return x * g;
  endfunction

  // drive command for one tick, updating the wheel state
  function automatic cmd_t pid_command(tick_t t);
    cmd_t c;
    longint unsigned dt, tmag, mag;
    longint delta, speed, err, integ, deriv, sum, lim, drv;
    c.wheel = t.wheel;
    c.drive = '0; c.fwd = '0; c.rev = '0; c.speed = '0;
    dt = (t.dt == 0) ? 1 : longint'(t.dt);
    delta = longint'(t.count) - longint'($signed(pred_last_count[t.wheel]));
    pred_last_count[t.wheel] = t.count;
    speed = clamp32(round_div(delta * longint'(cfg.metres_per_tick) * 1000000, dt << 16));
    c.speed = speed[31:0];
    tmag = t.target < 0 ? -longint'(t.target) : longint'(t.target);
    if (tmag < longint'(cfg.speed_deadband)) begin
      pred_integral[t.wheel] = 0;
      pred_prev_err[t.wheel] = 0;
      return c;
    end
    err = clamp32(longint'(t.target) - speed);
    integ = pred_integral[t.wheel] + round_div(err * longint'(dt), 1000000);
    if (integ > longint'(cfg.integral_clamp)) integ = longint'(cfg.integral_clamp);
    if (integ < -longint'(cfg.integral_clamp)) integ = -longint'(cfg.integral_clamp);
    pred_integral[t.wheel] = integ;
    deriv = round_div((err - pred_prev_err[t.wheel]) * 1000000, dt);
    pred_prev_err[t.wheel] = err;
    sum = gain_term(err, longint'(cfg.gain_p)) + gain_term(integ, longint'(cfg.gain_i))
        + gain_term(deriv, longint'(cfg.gain_d));
    sum += (t.target > 0 ? longint'(cfg.static_drive) : -longint'(cfg.static_drive)) <<< 24;
    lim = longint'(cfg.drive_limit) <<< 24;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    mag = sum < 0 ? longint'(-sum) : longint'(sum);
    mag = (mag + (64'd1 << 23)) >> 24;
    drv = sum < 0 ? -longint'(mag) : longint'(mag);
    c.drive = drv[8:0];
    c.fwd = drv > 0 ? drv[7:0] : 8'd0;
    c.rev = drv < 0 ? 8'(-drv) : 8'd0;
    return c;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || taken_cnt == sent_cnt) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_t t;
          t = pending_ticks.pop_front();
          wheel_number <= t.wheel;
          encoder_count <= t.count;
          target_speed <= t.target;
          elapsed_us <= t.dt;
          in_valid <= 1'b1;
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) begin
        tick_t t;
        t.wheel = wheel_number; t.count = encoder_count;
        t.target = target_speed; t.dt = elapsed_us;
        expected_cmds.push_back(pid_command(t));
        taken_cnt++;
      end
      if (out_valid && !out_stall) begin
        cmd_t e;
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected transfer, wheel", wheel_out, -1);
        end else begin
          e = expected_cmds.pop_front();
          if (wheel_out !== e.wheel) report_mismatch("wheel_out", wheel_out, e.wheel);
          if (drive_signed !== e.drive) report_mismatch("drive_signed", drive_signed, e.drive);
          if (bridge_fwd_duty !== e.fwd) report_mismatch("bridge_fwd_duty", bridge_fwd_duty, e.fwd);
          if (bridge_rev_duty !== e.rev) report_mismatch("bridge_rev_duty", bridge_rev_duty, e.rev);
          if (measured_speed !== e.speed) report_mismatch("measured_speed", measured_speed, e.speed);
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic load_config(wspf_pkg::cfg_t c);
    reg_write(wspf_pkg::REG_MPT, 32'(c.metres_per_tick));
    reg_write(wspf_pkg::REG_GAIN_P, 32'(c.gain_p));
    reg_write(wspf_pkg::REG_GAIN_I, 32'(c.gain_i));
    reg_write(wspf_pkg::REG_GAIN_D, 32'(c.gain_d));
    reg_write(wspf_pkg::REG_ICLAMP, 32'(c.integral_clamp));
    reg_write(wspf_pkg::REG_DEADBAND, 32'(c.speed_deadband));
    reg_write(wspf_pkg::REG_STATIC, 32'(c.static_drive));
    reg_write(wspf_pkg::REG_DLIMIT, 32'(c.drive_limit));
    cfg = c;
  endtask

  task automatic add_tick(logic [1:0] w, logic signed [15:0] cnt,
                          logic signed [19:0] tgt, logic [15:0] dt);
    tick_t t;
    t.wheel = w; t.count = cnt; t.target = tgt; t.dt = dt;
    gen_count[w] = cnt;
    pending_ticks.push_back(t);
  endtask

  // mostly plausible control ticks, some noise
  task automatic add_random_tick();
    logic [1:0] w;
    logic signed [15:0] cnt;
    logic signed [19:0] tgt;
    logic [15:0] dt;
    int r;
    w = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 80) cnt = gen_count[w] + 16'($urandom_range(400) - 200);
    else cnt = 16'($urandom);
    r = $urandom_range(99);
    if (r < 65) tgt = 20'($urandom_range(131072) - 65536);
    else if (r < 80) tgt = 20'($urandom_range(600) - 300);
    else if (r < 90) tgt = 20'($urandom_range(524288) - 262144);
    else tgt = 20'($urandom);
    r = $urandom_range(99);
    if (r < 75) dt = 16'($urandom_range(20000, 5000));
    else if (r < 85) dt = 16'($urandom_range(3));
    else dt = 16'($urandom);
    add_tick(w, cnt, tgt, dt);
  endtask

  task automatic drain();
    while (pending_ticks.size() > 0 || taken_cnt != sent_cnt || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    wspf_pkg::cfg_t c;
    for (int i = 0; i < wspf_pkg::WHEEL_COUNT; i++) begin
      pred_last_count[i] = '0; pred_integral[i] = 0; pred_prev_err[i] = 0; gen_count[i] = '0;
    end
    cfg.metres_per_tick = 24'd3189120; cfg.gain_p = 24'd30720; cfg.gain_i = 24'd25600;
    cfg.gain_d = 24'd1280; cfg.integral_clamp = 23'd78643; cfg.speed_deadband = 17'd131;
    cfg.static_drive = 8'd100; cfg.drive_limit = 8'd180;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      c = cfg;
      case (ph)
        1: begin
          c.metres_per_tick = '1; c.gain_p = '1; c.gain_i = '1; c.gain_d = '1;
          c.integral_clamp = 23'd4194304; c.speed_deadband = 17'd65536;
          c.static_drive = 8'd255; c.drive_limit = 8'd255;
        end
        2: begin
          c.metres_per_tick = '0; c.gain_p = '0; c.gain_i = '0; c.gain_d = '0;
          c.integral_clamp = '0; c.speed_deadband = '0;
          c.static_drive = '0; c.drive_limit = '0;
        end
        3: begin
          c.metres_per_tick = 24'd3189120; c.gain_p = 24'd30720; c.gain_i = 24'd25600;
          c.gain_d = 24'd1280; c.integral_clamp = 23'd78643; c.speed_deadband = '0;
          c.static_drive = 8'd100; c.drive_limit = 8'd255;
        end
        default: if (ph > 0) begin
          c.metres_per_tick = 24'($urandom); c.gain_p = 24'($urandom_range(200000));
          c.gain_i = 24'($urandom_range(200000)); c.gain_d = 24'($urandom);
          c.integral_clamp = 23'($urandom_range(4194304));
          c.speed_deadband = 17'($urandom_range(65536));
          c.static_drive = 8'($urandom); c.drive_limit = 8'($urandom);
        end
      endcase
      if (ph > 0) load_config(c);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 84 : 37) : 0;
      stall_pct = (ph % 4 == 2) ? 84 : (ph % 4 == 3 ? 37 : 0);

      if (ph == 0 || ph == 3) begin
        // directed: count and target extremes, deadband, zero and long times
        add_tick(2'd0, 16'sd32767, 20'sd262144, 16'd1);
        add_tick(2'd0, 16'sh8000, -20'sd262144, 16'd1);
        add_tick(2'd0, 16'sd32767, 20'sd262144, 16'd65535);
        add_tick(2'd1, 16'sd100, 20'sd0, 16'd10000);
        add_tick(2'd1, 16'sd200, 20'sd130, 16'd10000);
        add_tick(2'd1, 16'sd300, -20'sd131, 16'd10000);
        add_tick(2'd1, 16'sd400, 20'sd131, 16'd0);
        add_tick(2'd2, -16'sd5, 20'sd65536, 16'd10000);
        add_tick(2'd2, -16'sd10, -20'sd65536, 16'd10000);
        add_tick(2'd2, -16'sd15, 20'sh7FFFF, 16'd20000);
        add_tick(2'd2, -16'sd20, 20'sh80000, 16'd20000);
        add_tick(2'd3, 16'sd0, 20'sd0, 16'd0);
        add_tick(2'd3, 16'sh7FFF, 20'sd40000, 16'd65535);
        add_tick(2'd3, 16'sh8000, -20'sd40000, 16'd1);
        for (int k = 0; k < 6; k++) add_tick(2'd0, 16'sd32767 - 16'(k), 20'sd100000, 16'd10000);
      end
      for (int k = 0; k < 190; k++) add_random_tick();
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: wheel_speed_pid_with_static_feedforward_unit.f
sv/wspf_pkg.sv
sv/wspf_ram.sv
sv/wspf_mul.sv
sv/wspf_div.sv
sv/wspf_cfg.sv
sv/wspf_core.sv
sv/wheel_speed_pid_with_static_feedforward_unit.sv
verif/tb.sv
